### hw/rtl/art_pkg.sv
// Package for the access rights table: field widths, codes and transfer types.
`default_nettype none

package art_pkg;

    localparam int ENTRIES_DEFAULT = 64;

    localparam int KIND_W = 3;
    localparam int ID_W   = 32;
    localparam int ROLE_W = 2;
    localparam int STAT_W = 3;

    localparam logic [KIND_W-1:0] KIND_GRANT      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REVOKE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REVOKE_ALL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GUARDED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

    localparam logic [ROLE_W-1:0] ROLE_OWNER  = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_EDITOR = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_VIEWER = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_OWNER = 3'd1;
    localparam logic [STAT_W-1:0] ST_SELF      = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_ENTRY  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   doc_id;
        logic [ID_W-1:0]   user_id;
        logic [ID_W-1:0]   target_id;
        logic [ROLE_W-1:0] new_role;
    } art_req_t;

    typedef struct packed {
        logic              found;
        logic [ROLE_W-1:0] role_held;
        logic              may_read;
        logic              may_edit;
        logic              may_manage;
        logic [STAT_W-1:0] status;
    } art_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/art_cam.sv
// Entry registers of the rights table with parallel key compare and update.
`default_nettype none

module art_cam #(
    parameter int ENTRIES = art_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [art_pkg::ID_W-1:0]  key_doc,
    input  wire logic [art_pkg::ID_W-1:0]  key_user,
    input  wire logic [art_pkg::ID_W-1:0]  key_target,
    input  wire logic [ENTRIES-1:0]        wr_sel,
    input  wire logic [art_pkg::ROLE_W-1:0] wr_role,
    input  wire logic [ENTRIES-1:0]        clr_sel,
    output logic [ENTRIES-1:0]             valid,
    output logic [ENTRIES-1:0]             doc_hit,
    output logic [ENTRIES-1:0]             user_hit,
    output logic [ENTRIES-1:0]             target_hit,
    output logic [art_pkg::ROLE_W-1:0]     user_role,
    output logic                           user_owner
);
    import art_pkg::*;

    logic [ENTRIES-1:0] valid_reg;
    logic [ID_W-1:0]    doc_reg  [ENTRIES];
    logic [ID_W-1:0]    user_reg [ENTRIES];
    logic [ROLE_W-1:0]  role_reg [ENTRIES];

    assign valid = valid_reg;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign doc_hit[g]    = valid_reg[g] && (doc_reg[g] == key_doc);
        assign user_hit[g]   = doc_hit[g] && (user_reg[g] == key_user);
        assign target_hit[g] = doc_hit[g] && (user_reg[g] == key_target);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (wr_sel[g])
            begin
                valid_reg[g] <= 1'b1;
            end
            else if (clr_sel[g])
            begin
                valid_reg[g] <= 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr_sel[g])
            begin
                doc_reg[g]  <= key_doc;
                user_reg[g] <= key_user;
                role_reg[g] <= wr_role;
            end
        end
    end

    // keys are unique, so at most one entry hits and an OR merges its role
    always_comb
    begin
        user_role  = '0;
        user_owner = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (user_hit[i])
            begin
                user_role  = user_role | role_reg[i];
                user_owner = user_owner | (role_reg[i] == ROLE_OWNER);
            end
        end
    end

    a_user_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(user_hit))
        else $error("two entries hold the same key");

    a_target_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(target_hit))
        else $error("two entries hold the same target key");

    a_wr_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_sel & clr_sel) == '0)
        else $error("entry written and cleared at once");

    a_wr_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_sel) |=> ((valid_reg & $past(wr_sel)) == $past(wr_sel)))
        else $error("written entry not valid");

endmodule

`default_nettype wire

### hw/rtl/access_rights_table.sv
// Top level of the access rights table: request register, operation logic, result register.
//
// Usage:
//   req channel (req_valid / req_ready / req) carries one operation per transfer:
//   grant, revoke, revoke all of a document, guarded revoke or query.
//   rsp channel (rsp_valid / rsp_ready / rsp) returns exactly one result per
//   request, in request order.
//   Order: a request taken is held in the request register, is compared against
//   all entries, and is applied when it advances, which also loads its result
//   into the result register; a held result stalls that advance.
//   Throughput: one operation per cycle unless rsp is held; every entry is compared
//   in parallel and updated in the same cycle, so each operation sees all earlier updates.
//   Reset: rst_n clears every entry valid bit and the valid bits of both pipeline registers;
//   the table is usable right after reset, with no clearing pass.
//   Stall: while rsp is held by the receiver, the pending request waits in the
//   request register and req_ready drops once that register is occupied.
`default_nettype none

module access_rights_table #(
    parameter int ENTRIES = art_pkg::ENTRIES_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire art_pkg::art_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output art_pkg::art_rsp_t      rsp
);
    import art_pkg::*;

    logic     op_valid_reg;
    art_req_t op_reg;
    logic     rsp_valid_reg;
    art_rsp_t rsp_reg;
    art_rsp_t rsp_next;

    logic advance;

    logic [ENTRIES-1:0] valid;
    logic [ENTRIES-1:0] doc_hit;
    logic [ENTRIES-1:0] user_hit;
    logic [ENTRIES-1:0] target_hit;
    logic [ROLE_W-1:0]  user_role;
    logic               user_owner;
    logic [ENTRIES-1:0] low_free;
    logic [ENTRIES-1:0] wr_sel;
    logic [ENTRIES-1:0] clr_sel;
    logic [ROLE_W-1:0]  grant_role;

    assign advance   = op_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !op_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // lowest clear bit of the valid vector
    assign low_free   = ~valid & (valid + {{(ENTRIES-1){1'b0}}, 1'b1});
    assign grant_role = (op_reg.new_role > ROLE_VIEWER) ? ROLE_VIEWER : op_reg.new_role;

    art_cam #(
        .ENTRIES (ENTRIES)
    ) u_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_doc    (op_reg.doc_id),
        .key_user   (op_reg.user_id),
        .key_target (op_reg.target_id),
        .wr_sel     (wr_sel),
        .wr_role    (grant_role),
        .clr_sel    (clr_sel),
        .valid      (valid),
        .doc_hit    (doc_hit),
        .user_hit   (user_hit),
        .target_hit (target_hit),
        .user_role  (user_role),
        .user_owner (user_owner)
    );

    always_comb
    begin
        rsp_next = '0;
        wr_sel   = '0;
        clr_sel  = '0;
        case (op_reg.kind)
            KIND_GRANT:
            begin
                if (|user_hit)
                begin
                    wr_sel = user_hit;
                end
                else if (|low_free)
                begin
                    wr_sel = low_free;
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            KIND_REVOKE:
            begin
                if (|user_hit)
                begin
                    clr_sel = user_hit;
                end
                else
                begin
                    rsp_next.status = ST_NO_ENTRY;
                end
            end
            KIND_REVOKE_ALL:
            begin
                clr_sel = doc_hit;
            end
            KIND_GUARDED:
            begin
                if (!user_owner)
                begin
                    rsp_next.status = ST_NOT_OWNER;
                end
                else if (op_reg.user_id == op_reg.target_id)
                begin
                    rsp_next.status = ST_SELF;
                end
                else if (|target_hit)
                begin
                    clr_sel = target_hit;
                end
                else
                begin
                    rsp_next.status = ST_NO_ENTRY;
                end
            end
            KIND_QUERY:
            begin
                if (|user_hit)
                begin
                    rsp_next.found      = 1'b1;
                    rsp_next.role_held  = user_role;
                    rsp_next.may_read   = 1'b1;
                    rsp_next.may_edit   = (user_role == ROLE_OWNER) ||
                                          (user_role == ROLE_EDITOR);
                    rsp_next.may_manage = (user_role == ROLE_OWNER);
                end
                else
                begin
                    rsp_next.status = ST_NO_ENTRY;
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
        if (!advance)
        begin
            wr_sel  = '0;
            clr_sel = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                op_valid_reg <= req_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            op_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    a_op_hold: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid_reg && !advance |=> op_valid_reg && $stable(op_reg))
        else $error("pending request lost while result stalled");

    a_fail_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_DONE) |-> !rsp.found && !rsp.may_read)
        else $error("failed operation reports an entry");

    a_grant_hit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg.kind == KIND_GRANT) && (|user_hit)
        |=> rsp.status == ST_DONE)
        else $error("grant of existing key reported failure");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (op_reg.kind == KIND_GRANT) && (|low_free)
        |=> rsp.status != ST_FULL)
        else $error("grant reported full with a free entry");

endmodule

`default_nettype wire

### verif/access_rights_checker.sv
// Checker for the access rights table: mirrors the entry table and compares every result.
`timescale 1ns / 1ps

module access_rights_checker #(
    parameter int SLOTS = art_pkg::ENTRIES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  art_pkg::art_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  art_pkg::art_rsp_t rsp,
    output int                errors,
    output int                outstanding,
    output int                checked
);
    import art_pkg::*;

    logic              slot_used [SLOTS];
    logic [ID_W-1:0]   slot_doc  [SLOTS];
    logic [ID_W-1:0]   slot_user [SLOTS];
    logic [ROLE_W-1:0] slot_role [SLOTS];
    art_rsp_t          expected_rsp_q [$];

    function automatic int lookup_slot(input logic [ID_W-1:0] doc,
                                       input logic [ID_W-1:0] user);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_used[i] && slot_doc[i] == doc && slot_user[i] == user)
                return i;
        end
        return -1;
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_used[i])
                return i;
        end
        return -1;
    endfunction

    // Applies one operation to the mirrored table and returns its result.
    function automatic art_rsp_t apply_rights_op(input art_req_t op);
        art_rsp_t          res;
        logic [ROLE_W-1:0] role;
        int                s;
        res = '0;
        res.status = ST_DONE;
        case (op.kind)
            KIND_GRANT:
            begin
                // undefined role code degrades to least privilege
                role = (op.new_role > ROLE_VIEWER) ? ROLE_VIEWER : op.new_role;
                s = lookup_slot(op.doc_id, op.user_id);
                if (s < 0)
                    s = first_free_slot();
                if (s < 0)
                    res.status = ST_FULL;
                else
                begin
                    slot_used[s] = 1'b1;
                    slot_doc[s]  = op.doc_id;
                    slot_user[s] = op.user_id;
                    slot_role[s] = role;
                end
            end
            KIND_REVOKE:
            begin
                s = lookup_slot(op.doc_id, op.user_id);
                if (s < 0)
                    res.status = ST_NO_ENTRY;
                else
                    slot_used[s] = 1'b0;
            end
            KIND_REVOKE_ALL:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_used[i] && slot_doc[i] == op.doc_id)
                        slot_used[i] = 1'b0;
                end
            end
            KIND_GUARDED:
            begin
                s = lookup_slot(op.doc_id, op.user_id);
                if (s < 0)
                    res.status = ST_NOT_OWNER;
                else if (slot_role[s] != ROLE_OWNER)
                    res.status = ST_NOT_OWNER;
                else if (op.user_id == op.target_id)
                    res.status = ST_SELF;
                else
                begin
                    s = lookup_slot(op.doc_id, op.target_id);
                    if (s < 0)
                        res.status = ST_NO_ENTRY;
                    else
                        slot_used[s] = 1'b0;
                end
            end
            KIND_QUERY:
            begin
                s = lookup_slot(op.doc_id, op.user_id);
                if (s < 0)
                    res.status = ST_NO_ENTRY;
                else
                begin
                    res.found      = 1'b1;
                    res.role_held  = slot_role[s];
                    res.may_read   = 1'b1;
                    res.may_edit   = (slot_role[s] == ROLE_OWNER) ||
                                     (slot_role[s] == ROLE_EDITOR);
                    res.may_manage = (slot_role[s] == ROLE_OWNER);
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [2:0] want,
                                 input logic [2:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_rsp(input art_rsp_t got);
        art_rsp_t want;
        if (expected_rsp_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            return;
        end
        want = expected_rsp_q.pop_front();
        checked++;
        compare_field("found", 3'(want.found), 3'(got.found));
        compare_field("role_held", 3'(want.role_held), 3'(got.role_held));
        compare_field("may_read", 3'(want.may_read), 3'(got.may_read));
        compare_field("may_edit", 3'(want.may_edit), 3'(got.may_edit));
        compare_field("may_manage", 3'(want.may_manage), 3'(got.may_manage));
        compare_field("status", want.status, got.status);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            expected_rsp_q.delete();
            errors      = 0;
            outstanding = 0;
            checked     = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
                check_rsp(rsp);
            if (req_valid && req_ready)
                expected_rsp_q = {expected_rsp_q, apply_rights_op(req)};
            outstanding = expected_rsp_q.size();
        end
    end

endmodule

### verif/tb_access_rights_table.sv
// Testbench top for the access rights table: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_access_rights_table;
    import art_pkg::*;

    localparam int WATCHDOG_CYCLES   = 2000;
    localparam int END_SETTLE_CYCLES = 8;
    localparam int DOC_POOL          = 6;
    localparam int USER_POOL         = 12;
    localparam int FILL_GRANTS       = ENTRIES_DEFAULT + 2;
    localparam int RANDOM_OPS        = 115;
    localparam int FULL_TABLE_OPS    = 20;

    localparam logic [KIND_W-1:0] KIND_NOP_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NOP_HI = 3'd7;
    localparam logic [ROLE_W-1:0] ROLE_UNDEF  = 2'd3;
    localparam logic [ID_W-1:0]   ID_MIN      = '0;
    localparam logic [ID_W-1:0]   ID_MAX      = '1;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    art_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    art_rsp_t rsp;

    int errors;
    int outstanding;
    int checked;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int stall_cycles      = 0;
    int kind_count [8];
    int nop_total;

    logic [ID_W-1:0] doc_pool  [DOC_POOL];
    logic [ID_W-1:0] user_pool [USER_POOL];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    access_rights_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    access_rights_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_CYCLES)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("Mismatches found");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic art_req_t make_op(input logic [KIND_W-1:0] kind,
                                         input logic [ID_W-1:0] doc,
                                         input logic [ID_W-1:0] user,
                                         input logic [ID_W-1:0] target,
                                         input logic [ROLE_W-1:0] role);
        art_req_t op;
        op.kind      = kind;
        op.doc_id    = doc;
        op.user_id   = user;
        op.target_id = target;
        op.new_role  = role;
        return op;
    endfunction

    // Mostly keys from small pools so entries get hit; a few ops carry fresh ids.
    function automatic art_req_t random_op();
        art_req_t op;
        int       pick;
        pick         = $urandom_range(99);
        op.doc_id    = doc_pool[$urandom_range(DOC_POOL - 1)];
        op.user_id   = user_pool[$urandom_range(USER_POOL - 1)];
        op.target_id = user_pool[$urandom_range(USER_POOL - 1)];
        op.new_role  = ROLE_W'($urandom_range(ROLE_UNDEF));
        if (pick < 36)
            op.kind = KIND_GRANT;
        else if (pick < 60)
            op.kind = KIND_QUERY;
        else if (pick < 76)
            op.kind = KIND_GUARDED;
        else if (pick < 88)
            op.kind = KIND_REVOKE;
        else if (pick < 93)
            op.kind = KIND_REVOKE_ALL;
        else if (pick < 96)
            op.kind = KIND_W'($urandom_range(KIND_NOP_HI, KIND_NOP_LO));
        else
        begin
            op.kind      = KIND_W'($urandom_range(KIND_NOP_HI));
            op.doc_id    = $urandom;
            op.user_id   = $urandom;
            op.target_id = $urandom;
        end
        if (op.kind == KIND_GUARDED && $urandom_range(4) == 0)
            op.target_id = op.user_id;
        return op;
    endfunction

    task automatic send_op(input art_req_t op);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= op;
        kind_count[op.kind]++;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    task automatic run_phase(input int tx_idle, input int rx_idle);
        logic [ID_W-1:0] fill_doc;
        logic [ID_W-1:0] fill_base;
        sender_idle_pct   = tx_idle;
        receiver_idle_pct = rx_idle;
        fill_doc          = $urandom;
        fill_base         = $urandom;
        for (int i = 0; i < RANDOM_OPS / 2; i++)
            send_op(random_op());
        // distinct keys beyond capacity: the table must run full
        for (int i = 0; i < FILL_GRANTS; i++)
            send_op(make_op(KIND_GRANT, fill_doc, fill_base + i, $urandom,
                            ROLE_W'($urandom_range(ROLE_UNDEF))));
        wait_results_drained();
        send_op(make_op(KIND_QUERY, fill_doc, fill_base, $urandom, ROLE_OWNER));
        send_op(make_op(KIND_QUERY, fill_doc, fill_base + FILL_GRANTS - 1, $urandom,
                        ROLE_OWNER));
        for (int i = 0; i < FULL_TABLE_OPS; i++)
            send_op(random_op());
        send_op(make_op(KIND_REVOKE_ALL, fill_doc, $urandom, $urandom, ROLE_OWNER));
        for (int i = RANDOM_OPS / 2 + FULL_TABLE_OPS; i < RANDOM_OPS; i++)
            send_op(random_op());
    endtask

    initial
    begin
        doc_pool[0]  = ID_MIN;
        doc_pool[1]  = ID_MAX;
        user_pool[0] = ID_MIN;
        user_pool[1] = ID_MAX;
        for (int i = 2; i < DOC_POOL; i++)
            doc_pool[i] = $urandom;
        for (int i = 2; i < USER_POOL; i++)
            user_pool[i] = $urandom;
        foreach (kind_count[k])
            kind_count[k] = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct   = 12;
        receiver_idle_pct = 86;
        send_op(make_op(KIND_QUERY, ID_MIN, ID_MIN, $urandom, ROLE_OWNER));
        send_op(make_op(KIND_REVOKE, ID_MIN, ID_MIN, $urandom, ROLE_OWNER));
        send_op(make_op(KIND_GRANT, ID_MAX, ID_MAX, $urandom, ROLE_OWNER));
        send_op(make_op(KIND_QUERY, ID_MAX, ID_MAX, $urandom, ROLE_VIEWER));
        send_op(make_op(KIND_GRANT, ID_MAX, ID_MAX, $urandom, ROLE_EDITOR));
        send_op(make_op(KIND_QUERY, ID_MAX, ID_MAX, $urandom, ROLE_OWNER));
        send_op(make_op(KIND_GRANT, ID_MAX, ID_MAX, $urandom, ROLE_UNDEF));
        send_op(make_op(KIND_QUERY, ID_MAX, ID_MAX, $urandom, ROLE_UNDEF));
        send_op(make_op(KIND_GUARDED, ID_MAX, ID_MAX, ID_MIN, ROLE_OWNER));
        send_op(make_op(KIND_GUARDED, ID_MIN, ID_MIN, ID_MAX, ROLE_OWNER));
        send_op(make_op(KIND_GRANT, ID_MIN, ID_MIN, $urandom, ROLE_OWNER));
        send_op(make_op(KIND_GUARDED, ID_MIN, ID_MIN, ID_MIN, ROLE_OWNER));
        send_op(make_op(KIND_GUARDED, ID_MIN, ID_MIN, ID_MAX, ROLE_OWNER));
        send_op(make_op(KIND_GRANT, ID_MIN, ID_MAX, $urandom, ROLE_EDITOR));
        send_op(make_op(KIND_GUARDED, ID_MIN, ID_MIN, ID_MAX, ROLE_OWNER));
        send_op(make_op(KIND_QUERY, ID_MIN, ID_MAX, $urandom, ROLE_OWNER));
        send_op(make_op(KIND_REVOKE, ID_MIN, ID_MIN, $urandom, ROLE_OWNER));
        send_op(make_op(KIND_REVOKE_ALL, $urandom, $urandom, $urandom, ROLE_OWNER));
        send_op(make_op(KIND_GRANT, ID_MIN, ID_MAX, $urandom, ROLE_VIEWER));
        send_op(make_op(KIND_REVOKE_ALL, ID_MAX, $urandom, $urandom, ROLE_OWNER));
        send_op(make_op(KIND_QUERY, ID_MAX, ID_MAX, $urandom, ROLE_OWNER));
        send_op(make_op(KIND_REVOKE_ALL, ID_MIN, $urandom, $urandom, ROLE_OWNER));
        for (int k = KIND_NOP_LO; k <= KIND_NOP_HI; k++)
            send_op(make_op(KIND_W'(k), $urandom, $urandom, $urandom,
                            ROLE_W'($urandom_range(ROLE_UNDEF))));
        wait_results_drained();

        run_phase(12, 86);
        run_phase(86, 12);
        run_phase(0, 0);

        wait_results_drained();
        repeat (END_SETTLE_CYCLES) @(negedge clk);

        nop_total = 0;
        for (int k = KIND_NOP_LO; k <= KIND_NOP_HI; k++)
            nop_total += kind_count[k];
        $display("Covered: %0d grants, %0d revokes, %0d document sweeps, %0d guarded,",
                 kind_count[KIND_GRANT], kind_count[KIND_REVOKE], kind_count[KIND_REVOKE_ALL],
                 kind_count[KIND_GUARDED]);
        $display("  %0d queries, %0d unused codes; %0d results compared across a full table",
                 kind_count[KIND_QUERY], nop_total, checked);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
